// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Operation and status codes, channel widths and the control word that is
// broadcast from the decoder to every storage cell.
// ----------------------------------------------------------------------------
package ple_pkg;

  // channel field widths
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int LEN_W    = 5;

  // packed word widths, padded to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_BEYOND   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // shift command seen by every cell
  typedef struct packed {
    logic             ins;   // open a gap at pos and load the key word
    logic             del;   // close the gap at pos
    logic [POS_W-1:0] pos;   // cell index where the shift starts
  } ple_ctl_t;

endpackage

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list
// Holds one entry, takes its left or right neighbor's word on a shift, loads
// the key word on an insert at its own index and compares itself to the key.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ple_pkg::ple_ctl_t     ctl,
  input  logic [ple_pkg::POS_W-1:0] count,
  input  logic [DATA_WIDTH-1:0] key_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // shift selection
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX == ctl.pos) begin
        data_nxt = key_word;
      end else if (MY_IDX > ctl.pos) begin
        data_nxt = left_data;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= ctl.pos) begin
        data_nxt = right_data;
      end
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // local compare, only occupied cells count
  assign match = (MY_IDX < count) && (data_r == key_word);
  assign data  = data_r;

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed words with insert and delete
// by position and search by key, held in a row of shifting cells
//
//   channel | dir | fields (low bit first)
//   --------+-----+-----------------------------------------------
//   in_     | in  | opcode[2:0] key_value[34:3] position[42:35]
//   out_    | out | status[2:0] found_index[6:3] length[11:7]
//
// One operation is accepted per cycle unless stalled; all cells shift or
// compare in the cycle of acceptance. The result passes two registered
// stages: one holds the cell match vector, the next the encoded first match.
// A stalled output holds its word and back-pressures the input through the
// two stages. Synchronous active-low reset empties the list; no clear sweep.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode, key_value, position, zero pad
  input  logic [ple_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, found_index, length, zero pad
  output logic [ple_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  // input word fields
  logic [OP_W-1:0]         in_op;
  logic signed [KEY_W-1:0] in_key;
  logic [POS_W-1:0]        in_pos;
  logic [DATA_WIDTH-1:0]   key_word;

  assign in_op    = in_tdata[OP_W-1:0];
  assign in_key   = in_tdata[OP_W+KEY_W-1:OP_W];
  assign in_pos   = in_tdata[OP_W+KEY_W+POS_W-1:OP_W+KEY_W];
  assign key_word = DATA_WIDTH'(in_key);

  logic in_acc;
  logic s1_adv;

  assign in_acc = in_tvalid && in_tready;

  // list length
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [POS_W-1:0] cnt_pos;

  assign cnt_pos = POS_W'(count_r);

  // operation decode
  ple_ctl_t ctl;
  status_t  dec_status;
  logic     dec_inc;
  logic     dec_dec;
  logic     dec_search;

  always_comb begin
    ctl        = '0;
    dec_status = ST_OK;
    dec_inc    = 1'b0;
    dec_dec    = 1'b0;
    dec_search = 1'b0;
    unique case (in_op)
      OP_INS_FIRST: begin
        if (cnt_pos >= CAP_POS) begin
          dec_status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          dec_inc = 1'b1;
        end
      end
      OP_INS_LAST: begin
        ctl.pos = cnt_pos;
        if (cnt_pos >= CAP_POS) begin
          dec_status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          dec_inc = 1'b1;
        end
      end
      OP_INS_AT: begin
        ctl.pos = in_pos;
        if (in_pos[POS_W-1]) begin
          dec_status = ST_BADPOS;
        end else if (in_pos > cnt_pos) begin
          dec_status = ST_BEYOND;
        end else if (cnt_pos >= CAP_POS) begin
          dec_status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          dec_inc = 1'b1;
        end
      end
      OP_DEL_FIRST: begin
        if (cnt_pos == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          ctl.del = 1'b1;
          dec_dec = 1'b1;
        end
      end
      OP_DEL_LAST: begin
        // tail entry simply drops out of the occupied range
        if (cnt_pos == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_dec = 1'b1;
        end
      end
      OP_DEL_AT: begin
        ctl.pos = in_pos;
        if (in_pos[POS_W-1]) begin
          dec_status = ST_BADPOS;
        end else if (in_pos == '0 && cnt_pos == '0) begin
          dec_status = ST_EMPTY;
        end else if (in_pos >= cnt_pos) begin
          dec_status = ST_BEYOND;
        end else begin
          ctl.del = 1'b1;
          dec_dec = 1'b1;
        end
      end
      OP_SEARCH: begin
        dec_search = 1'b1;
      end
      default: begin
        // unused code leaves the list alone
      end
    endcase
    ctl.ins = ctl.ins && in_acc;
    ctl.del = ctl.del && in_acc;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && dec_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (in_acc && dec_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (g == 0) begin : g_head
      assign left_w = key_word;
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body
      assign right_w = cell_data[g+1];
    end

    ple_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (cnt_pos),
      .key_word   (key_word),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // stage 1: decoded status and match vector
  logic                s1_valid_r;
  status_t             s1_status_r;
  logic                s1_search_r;
  logic [CAPACITY-1:0] s1_match_r;
  logic [CW-1:0]       s1_len_r;
  logic                out_valid_r;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= dec_status;
      s1_search_r <= dec_search;
      s1_match_r  <= cell_match;
      s1_len_r    <= count_nxt;
    end
  end

  // first match encode
  logic          hit;
  logic [IW-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (s1_match_r[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // stage 2: output word
  logic [STATUS_W-1:0]   out_status_r;
  logic [FOUND_W-1:0]    out_found_r;
  logic [LEN_W-1:0]      out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      if (s1_search_r) begin
        out_status_r <= hit ? ST_OK : ST_NOTFOUND;
        out_found_r  <= hit ? FOUND_W'(hit_idx) : '0;
      end else begin
        out_status_r <= s1_status_r;
        out_found_r  <= '0;
      end
      out_len_r <= LEN_W'(s1_len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - FOUND_W - LEN_W){1'b0}},
                       out_len_r, out_found_r, out_status_r};

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec_status == ST_FULL) |-> count_r == CW'(CAPACITY))
    else $error("full reported below capacity");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("stage 1 word lost under stall");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_list_engine
// Drives list operations over the input stream and checks every result word
// against a behavioral list kept in a SystemVerilog queue. Covers the empty
// and full list, bad and out-of-range positions, extreme key words,
// duplicate keys and the unused opcode. It then runs rounds of random
// operations that fill, mix and drain the list, with random gaps on both
// sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int LATENCY      = 2;
  localparam int MAX_WAIT     = 14;
  localparam int RANDOM_ITEMS = 650;
  localparam int ROUND_ITEMS  = 50;
  localparam int REPORT_MAX   = 10;
  // timeout bound, far above the worst run of under 700 items
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PAD_W        = IN_DATA_W - OP_W - KEY_W - POS_W;

  // opcode outside the defined set, must leave the list alone
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_EVEN,
    MIX_DRAIN
  } op_mix_t;

  typedef struct {
    status_t            status;
    logic [FOUND_W-1:0] found;
    logic [LEN_W-1:0]   len;
  } list_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // opcode, key_value, position, zero pad
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // status, found_index, length, zero pad

  logic [KEY_W-1:0] held_words[$];
  list_result_t     pending_results[$];
  int               err_count;
  int               cycle_count;
  bit               idle_on;

  positional_list_engine #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(KEY_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // list behavior: applies one operation to held_words, returns its result
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] opc,
                                                 logic [KEY_W-1:0] key,
                                                 logic signed [POS_W-1:0] pos);
    list_result_t r;
    int n;
    int at;
    r.status = ST_OK;
    r.found  = '0;
    n        = held_words.size();
    case (opc)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (opc == OP_INS_FIRST) at = 0;
        else if (opc == OP_INS_LAST) at = n;
        else at = pos;
        // bad position wins over full
        if (at < 0) r.status = ST_BADPOS;
        else if (at > n) r.status = ST_BEYOND;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else held_words.insert(at, key);
      end
      OP_DEL_FIRST: begin
        if (n == 0) r.status = ST_EMPTY;
        else held_words.delete(0);
      end
      OP_DEL_LAST: begin
        if (n == 0) r.status = ST_EMPTY;
        else held_words.delete(n - 1);
      end
      OP_DEL_AT: begin
        if (pos < 0) r.status = ST_BADPOS;
        else if (pos == 0 && n == 0) r.status = ST_EMPTY;
        else if (pos >= n) r.status = ST_BEYOND;
        else held_words.delete(int'(pos));
      end
      OP_SEARCH: begin
        // first match only
        r.status = ST_NOTFOUND;
        foreach (held_words[i]) begin
          if (r.status == ST_NOTFOUND && held_words[i] == key) begin
            r.status = ST_OK;
            r.found  = FOUND_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(held_words.size());
    return r;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  // predict on every accepted input word
  always @(posedge clk) begin : predict_inputs
    list_result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = apply_list_op(in_tdata[OP_W-1:0], in_tdata[OP_W +: KEY_W],
                        in_tdata[OP_W+KEY_W +: POS_W]);
      pending_results.push_back(r);
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    list_result_t          want;
    logic [OUT_DATA_W-1:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        note_error($sformatf("result word %h with nothing pending", got));
      end else begin
        want = pending_results.pop_front();
        if (got[STATUS_W-1:0] !== want.status ||
            got[STATUS_W +: FOUND_W] !== want.found ||
            got[STATUS_W+FOUND_W +: LEN_W] !== want.len) begin
          note_error($sformatf(
            "status exp %0d got %0d, found_index exp %0d got %0d, length exp %0d got %0d",
            want.status, got[STATUS_W-1:0], want.found, got[STATUS_W +: FOUND_W],
            want.len, got[STATUS_W+FOUND_W +: LEN_W]));
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: random stall before each word
  initial begin : result_ready
    int stall;
    out_tready <= 1'b0;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // send one word, returns at the edge where it is taken
  task automatic send_word(input logic [OP_W-1:0] opc, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, pos, key, opc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender idles while every pending result comes back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // one random operation, weighted by the round's mix
  task automatic send_random_op(input op_mix_t mix);
    int               n;
    int               roll;
    int               sel;
    int               grp;  // 0 insert, 1 delete, 2 search
    logic [OP_W-1:0]  opc;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    n    = held_words.size();
    roll = $urandom_range(0, 99);
    sel  = $urandom_range(0, 2);
    case (mix)
      MIX_FILL:  grp = (roll < 70) ? 0 : (roll < 85) ? 2 : 1;
      MIX_DRAIN: grp = (roll < 70) ? 1 : (roll < 85) ? 2 : 0;
      default:   grp = (roll < 43) ? 0 : (roll < 86) ? 1 : 2;
    endcase
    if (grp == 0) opc = (sel == 0) ? OP_INS_FIRST : (sel == 1) ? OP_INS_LAST : OP_INS_AT;
    else if (grp == 1) opc = (sel == 0) ? OP_DEL_FIRST : (sel == 1) ? OP_DEL_LAST : OP_DEL_AT;
    else opc = OP_SEARCH;
    // keys: held words for hits, a small pool for duplicates, else anything
    if (grp == 2 && n > 0 && $urandom_range(0, 1) == 1)
      key = held_words[$urandom_range(0, n - 1)];
    else if ($urandom_range(0, 3) == 0)
      key = KEY_W'($urandom_range(0, 7)) - KEY_W'(4);
    else
      key = $urandom();
    // positions mostly in range, some anywhere
    if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, 255));
    else pos = POS_W'($urandom_range(0, n));
    send_word(opc, key, pos);
  endtask

  // every rejection on an empty list
  task automatic test_empty_list();
    send_word(OP_SEARCH,    32'h0000_0000, 8'h00);
    send_word(OP_DEL_FIRST, 32'h0000_0000, 8'h00);
    send_word(OP_DEL_LAST,  32'hffff_ffff, 8'h00);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h00);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h05);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h80);
    send_word(OP_INS_AT,    32'h1234_5678, 8'h01);
    send_word(OP_INS_AT,    32'h1234_5678, 8'h7f);
    send_word(OP_INS_AT,    32'h1234_5678, 8'hff);
  endtask

  // extreme key words, append by position, duplicates, unused opcode
  task automatic test_edge_words();
    send_word(OP_INS_FIRST, 32'h7fff_ffff, 8'h00);
    send_word(OP_INS_LAST,  32'h8000_0000, 8'h00);
    send_word(OP_INS_AT,    32'h0000_0000, 8'h02);
    send_word(OP_INS_AT,    32'hffff_ffff, 8'h01);
    send_word(OP_INS_AT,    32'h0000_0000, 8'h00);
    send_word(OP_SEARCH,    32'h0000_0000, 8'h00);
    send_word(OP_SEARCH,    32'h8000_0000, 8'h00);
    send_word(OP_SEARCH,    32'hffff_ffff, 8'hff);
    send_word(OP_SEARCH,    32'h1234_5678, 8'h00);
    send_word(OP_UNUSED,    32'hdead_beef, 8'h03);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h04);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h04);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h01);
    send_word(OP_DEL_LAST,  32'h0000_0000, 8'h00);
    send_word(OP_DEL_FIRST, 32'h0000_0000, 8'h00);
    send_word(OP_DEL_AT,    32'h0000_0000, 8'h00);
  endtask

  // rounds weighted to fill, mix, and drain the list
  task automatic test_random_ops();
    op_mix_t mix;
    for (int round = 0; round < RANDOM_ITEMS / ROUND_ITEMS; round++) begin
      mix     = (round % 3 == 0) ? MIX_FILL : (round % 3 == 1) ? MIX_EVEN : MIX_DRAIN;
      idle_on = (round % 4 != 3);
      repeat (ROUND_ITEMS) send_random_op(mix);
      // hold the sender until the pipe is empty now and then
      if (round % 5 == 4) drain_results();
    end
    idle_on = 1'b1;
  endtask

  // main sequence
  initial begin
    err_count   = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edge_words();
    test_random_ops();

    in_tvalid <= 1'b0;
    drain_results();
    repeat (LATENCY + 6) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
tb/testbench.sv
